@@ hdl/lcs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcs_pkg: shared types and constants for the load current setpoint block
// Field widths, command and mode codes, register indexes, table sizing and
// the request/response bundle of the serial divider.
// ----------------------------------------------------------------------------
package lcs_pkg;

  localparam int TABLE_ENTRIES = 64;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int CNT_W         = ($clog2(TABLE_ENTRIES + 1) > 7) ?
                                 $clog2(TABLE_ENTRIES + 1) : 7;

  localparam int CMD_W   = 2;
  localparam int MODE_W  = 3;
  localparam int TGT_W   = 24;
  localparam int PCNT_W  = 7;
  localparam int TIME_W  = 32;
  localparam int VOLT_W  = 16;
  localparam int EIDX_W  = 6;
  localparam int DUR_W   = 32;
  localparam int CUR_W   = 16;
  localparam int RIDX_W  = 2;
  localparam int CFG_W   = 24;

  // divider sizing: 24-bit operand times 1000 fits 34 bits
  localparam int NUM_W   = 34;
  localparam int QUOT_W  = 16;
  localparam int STEP_W  = 5;
  localparam int TRIAL_W = TGT_W + QUOT_W + 1;
  localparam logic [NUM_W-1:0] SCALE = NUM_W'(1000);

  localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_START = 2'd2;

  localparam logic [MODE_W-1:0] MODE_OFF    = 3'd0;
  localparam logic [MODE_W-1:0] MODE_CC     = 3'd1;
  localparam logic [MODE_W-1:0] MODE_CP     = 3'd2;
  localparam logic [MODE_W-1:0] MODE_CR     = 3'd3;
  localparam logic [MODE_W-1:0] MODE_PULSED = 3'd4;

  localparam logic [RIDX_W-1:0] REG_MODE   = 2'd0;
  localparam logic [RIDX_W-1:0] REG_TARGET = 2'd1;
  localparam logic [RIDX_W-1:0] REG_COUNT  = 2'd2;

  localparam logic [CUR_W-1:0] CUR_MAX = {CUR_W{1'b1}};

  typedef struct packed {
    logic [DUR_W-1:0] duration;
    logic [CUR_W-1:0] current;
  } entry_t;

  typedef struct packed {
    logic             start;
    logic [TGT_W-1:0] operand;
    logic [TGT_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic              sat;
    logic [QUOT_W-1:0] quotient;
  } div_rsp_t;

endpackage

@@ hdl/load_current_setpoint.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// load_current_setpoint: drive current setpoint for an electronic load
// Sequencer around a serial divider and a pulse entry memory.
// ----------------------------------------------------------------------------
// Usage:
//   Input items (valid/ready) carry a command: a control tick returns one
//   result item, a pulse entry load or a pulse sequence start returns none.
//   Config registers (mode, target, pulse count) are written through
//   write_enable/reg_index/write_data; the user must write them only while
//   the block is idle, the block itself does not enforce this.
//   One item is worked on at a time; in_ready is high only when idle.
//   Off, constant current, unknown mode and zero-divisor ticks go straight
//   to the result; pulsed ticks do a memory read, then compare/advance;
//   constant power and constant resistance ticks wait for the divider: a
//   multiply step, an overflow trial, then one quotient bit per cycle,
//   stopping after the trial on overflow. in_ready returns as the result
//   is loaded into the output register; load/start items stay idle.
//   The result sits in an output register; if the receiver stalls, the next
//   item is accepted but its result waits until the register is taken.
//   Reset (rst, synchronous) clears mode, target, position and start time
//   and sets the pulse count to 1; the pulse memory is not cleared.
// ----------------------------------------------------------------------------
module load_current_setpoint import lcs_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [CMD_W-1:0]  command,
  input  logic [TIME_W-1:0] time_us,
  input  logic [VOLT_W-1:0] voltage_mv,
  input  logic [EIDX_W-1:0] entry_index,
  input  logic [DUR_W-1:0]  entry_duration_us,
  input  logic [CUR_W-1:0]  entry_current_ma,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CUR_W-1:0]  drive_current_ma,
  output logic              saturated,
  input  logic              write_enable,
  input  logic [RIDX_W-1:0] reg_index,
  input  logic [CFG_W-1:0]  write_data
);

  typedef enum logic [2:0] {S_IDLE, S_PULSE_RD, S_PULSE_EVAL, S_DIV, S_EMIT} state_t;

  state_t              state;
  logic [MODE_W-1:0]   control_mode;
  logic [TGT_W-1:0]    target_value;
  logic [PCNT_W-1:0]   pulse_count;
  logic [IDX_W-1:0]    pulse_position;
  logic [TIME_W-1:0]   pulse_start_time;
  logic [TIME_W-1:0]   tick_time;
  logic [CUR_W-1:0]    res_value;
  logic                res_sat;

  logic                accept;
  logic                tbl_wr_en;
  entry_t              tbl_wr_data;
  entry_t              tbl_rd_data;
  div_req_t            div_req;
  div_rsp_t            div_rsp;

  logic [CNT_W-1:0]    count_ext;
  logic [CNT_W-1:0]    eff_count;
  logic [CNT_W-1:0]    next_pos_ext;
  logic [IDX_W-1:0]    pulse_position_next;
  logic [TIME_W-1:0]   elapsed;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  assign tbl_wr_en   = accept && (command == CMD_LOAD) &&
                       (32'(entry_index) < TABLE_ENTRIES);
  assign tbl_wr_data = '{duration: entry_duration_us, current: entry_current_ma};

  lcs_pulse_table u_table (
    .clk     (clk),
    .wr_en   (tbl_wr_en),
    .wr_addr (IDX_W'(entry_index)),
    .wr_data (tbl_wr_data),
    .rd_addr (pulse_position),
    .rd_data (tbl_rd_data)
  );

  always_comb begin
    div_req.start   = accept && (command == CMD_TICK) &&
                      (((control_mode == MODE_CP) && (voltage_mv != '0)) ||
                       ((control_mode == MODE_CR) && (target_value != '0)));
    div_req.operand = (control_mode == MODE_CP) ? target_value : TGT_W'(voltage_mv);
    div_req.divisor = (control_mode == MODE_CP) ? TGT_W'(voltage_mv) : target_value;
  end

  lcs_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // pulse sequencing: effective count clamps to 1..TABLE_ENTRIES
  always_comb begin
    count_ext = CNT_W'(pulse_count);
    if (count_ext == '0) begin
      eff_count = CNT_W'(1);
    end else if (count_ext > CNT_W'(TABLE_ENTRIES)) begin
      eff_count = CNT_W'(TABLE_ENTRIES);
    end else begin
      eff_count = count_ext;
    end
    next_pos_ext = CNT_W'(pulse_position) + CNT_W'(1);
    if (next_pos_ext >= eff_count) begin
      pulse_position_next = '0;
    end else begin
      pulse_position_next = next_pos_ext[IDX_W-1:0];
    end
    elapsed = tick_time - pulse_start_time;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      control_mode     <= MODE_OFF;
      target_value     <= '0;
      pulse_count      <= PCNT_W'(1);
      pulse_position   <= '0;
      pulse_start_time <= '0;
      out_valid        <= 1'b0;
    end else begin
      if ((state == S_EMIT) && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      if (write_enable) begin
        unique case (reg_index)
          REG_MODE:   control_mode <= write_data[MODE_W-1:0];
          REG_TARGET: target_value <= write_data[TGT_W-1:0];
          REG_COUNT:  pulse_count  <= write_data[PCNT_W-1:0];
          default: ;
        endcase
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            tick_time <= time_us;
            unique case (command)
              CMD_START: begin
                pulse_position   <= '0;
                pulse_start_time <= time_us;
                control_mode     <= MODE_PULSED;
              end
              CMD_TICK: begin
                res_sat <= 1'b0;
                unique case (control_mode)
                  MODE_OFF: begin
                    res_value <= '0;
                    state     <= S_EMIT;
                  end
                  MODE_CC: begin
                    if (target_value > TGT_W'(CUR_MAX)) begin
                      res_value <= CUR_MAX;
                      res_sat   <= 1'b1;
                    end else begin
                      res_value <= target_value[CUR_W-1:0];
                    end
                    state <= S_EMIT;
                  end
                  MODE_CP, MODE_CR: begin
                    if (div_req.start) begin
                      state <= S_DIV;
                    end else begin
                      // division by zero
                      res_value <= CUR_MAX;
                      res_sat   <= 1'b1;
                      state     <= S_EMIT;
                    end
                  end
                  MODE_PULSED: state <= S_PULSE_RD;
                  default: begin
                    control_mode <= MODE_OFF;
                    res_value    <= '0;
                    state        <= S_EMIT;
                  end
                endcase
              end
              default: ;
            endcase
          end
        end
        S_PULSE_RD: state <= S_PULSE_EVAL;
        S_PULSE_EVAL: begin
          // result is the entry active before any advance
          res_value <= tbl_rd_data.current;
          if (elapsed > tbl_rd_data.duration) begin
            pulse_start_time <= pulse_start_time + tbl_rd_data.duration;
            pulse_position   <= pulse_position_next;
          end
          state <= S_EMIT;
        end
        S_DIV: begin
          if (div_rsp.done) begin
            res_value <= div_rsp.sat ? CUR_MAX : div_rsp.quotient;
            res_sat   <= div_rsp.sat;
            state     <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!out_valid || out_ready) begin
            drive_current_ma <= res_value;
            saturated        <= res_sat;
            state            <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == S_DIV))
    else $error("divider finished outside the divide state");

  a_sat_is_max: assert property (@(posedge clk) disable iff (rst)
    (out_valid && saturated) |-> (drive_current_ma == CUR_MAX))
    else $error("saturated result is not full scale");

  a_fast_tick_emits: assert property (@(posedge clk) disable iff (rst)
    (accept && (command == CMD_TICK) &&
     ((control_mode == MODE_OFF) || (control_mode == MODE_CC)))
    |=> (state == S_EMIT))
    else $error("direct-mode tick did not go straight to emit");

  a_mode_legal_after_tick: assert property (@(posedge clk) disable iff (rst)
    (accept && (command == CMD_TICK) && !write_enable) |=>
    (control_mode <= MODE_PULSED))
    else $error("unknown mode survived a tick");
`endif

endmodule

@@ hdl/lcs_pulse_table.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcs_pulse_table: pulse entry memory
// One write port and one read port with registered read data. Entries hold
// a duration and a current; contents are undefined until written.
// ----------------------------------------------------------------------------
module lcs_pulse_table import lcs_pkg::*; (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  entry_t           wr_data,
  input  logic [IDX_W-1:0] rd_addr,
  output entry_t           rd_data
);

  entry_t mem [TABLE_ENTRIES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

@@ hdl/lcs_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcs_div: serial scaled divider
// Computes operand*1000/divisor one quotient bit per cycle with a single
// shared compare/subtract. The first trial (bit 16) detects overflow.
// ----------------------------------------------------------------------------
module lcs_div import lcs_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  typedef enum logic [1:0] {D_IDLE, D_MUL, D_STEP} dstate_t;

  dstate_t             dstate;
  logic [TGT_W-1:0]    operand;
  logic [TGT_W-1:0]    divisor;
  logic [NUM_W-1:0]    rem;
  logic [STEP_W-1:0]   step;
  logic [QUOT_W-1:0]   quot;
  logic                done;
  logic                sat;

  logic [TRIAL_W-1:0]  shifted;
  logic [TRIAL_W-1:0]  diff;
  logic                fits;

  always_comb begin
    shifted = TRIAL_W'(divisor) << step;
    diff    = TRIAL_W'(rem) - shifted;
    fits    = ~diff[TRIAL_W-1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dstate <= D_IDLE;
      done   <= 1'b0;
      sat    <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (dstate)
        D_IDLE: begin
          if (req.start) begin
            operand <= req.operand;
            divisor <= req.divisor;
            dstate  <= D_MUL;
          end
        end
        D_MUL: begin
          rem    <= NUM_W'(operand) * SCALE;
          step   <= STEP_W'(QUOT_W);
          dstate <= D_STEP;
        end
        D_STEP: begin
          if (fits) begin
            rem <= diff[NUM_W-1:0];
          end
          if (step == STEP_W'(QUOT_W)) begin
            // quotient would need a 17th bit
            if (fits) begin
              done   <= 1'b1;
              sat    <= 1'b1;
              dstate <= D_IDLE;
            end else begin
              step <= step - STEP_W'(1);
            end
          end else begin
            quot <= {quot[QUOT_W-2:0], fits};
            if (step == '0) begin
              done   <= 1'b1;
              sat    <= 1'b0;
              dstate <= D_IDLE;
            end else begin
              step <= step - STEP_W'(1);
            end
          end
        end
        default: dstate <= D_IDLE;
      endcase
    end
  end

  assign rsp = '{done: done, sat: sat, quotient: quot};

endmodule
